// File: sv/assert_macros.svh
// Assertion macros shared by the palette indexer RTL.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge.
`define ECPI_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a trigger in one cycle implies a condition in the same cycle.
`define ECPI_ASSERT_IMPLY(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) else $error(msg);

// Checks that a trigger in one cycle implies a condition in the next cycle.
`define ECPI_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) else $error(msg);

`endif

// File: sv/ecpi_pkg.sv
// Package for the exact colour palette indexer: transaction types, sizes,
// the sequencer's control word and its microcode table. Depends on nothing.
`default_nettype none

package ecpi_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
   localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
   localparam int COLOUR_W        = 24;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } req_type;

   typedef struct packed {
      logic [7:0] colour_index;
      logic       new_colour;
      logic       overflow;
      logic [8:0] entries_used;
      logic       image_done;
   } rsp_type;

   typedef enum logic [2:0] {
      S_WAIT,
      S_CHECK,
      S_SCAN,
      S_MISS,
      S_ADD,
      S_HIT,
      S_OVER
   } step_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_OVF,
      C_EMPTY,
      C_HIT,
      C_MORE,
      C_FULL,
      C_OUT_BUSY
   } cond_type;

   typedef enum logic [1:0] {
      IDX_ZERO,
      IDX_K,
      IDX_COUNT
   } idx_sel_type;

   typedef struct packed {
      logic        take;
      logic        k_step;
      logic        emit;
      logic        add;
      logic        set_ovf;
      idx_sel_type idx_sel;
      cond_type    j1_cond;
      step_type    j1_tgt;
      cond_type    j2_cond;
      step_type    j2_tgt;
   } ctrl_type;

   typedef struct packed {
      logic no_req;
      logic ovf;
      logic empty;
      logic hit;
      logic more;
      logic full;
      logic out_busy;
   } flags_type;

   function automatic logic cond_true(input cond_type c, input flags_type f);
      logic r;
      unique case (c)
         C_NEVER:    r = 1'b0;
         C_ALWAYS:   r = 1'b1;
         C_NO_REQ:   r = f.no_req;
         C_OVF:      r = f.ovf;
         C_EMPTY:    r = f.empty;
         C_HIT:      r = f.hit;
         C_MORE:     r = f.more;
         C_FULL:     r = f.full;
         C_OUT_BUSY: r = f.out_busy;
         default:    r = 1'b0;
      endcase
      return r;
   endfunction

   // The first jump wins over the second; with neither taken the step counter advances.
   // In the scan step the index advances only when the first jump is not taken.
   function automatic ctrl_type ucode(input step_type s);
      ctrl_type c;
      c         = '0;
      c.idx_sel = IDX_ZERO;
      c.j1_cond = C_NEVER;
      c.j1_tgt  = S_WAIT;
      c.j2_cond = C_NEVER;
      c.j2_tgt  = S_WAIT;
      unique case (s)
         S_WAIT: begin
            c.take    = 1'b1;
            c.j1_cond = C_NO_REQ;
            c.j1_tgt  = S_WAIT;
         end
         S_CHECK: begin
            c.j1_cond = C_OVF;
            c.j1_tgt  = S_OVER;
            c.j2_cond = C_EMPTY;
            c.j2_tgt  = S_MISS;
         end
         S_SCAN: begin
            c.k_step  = 1'b1;
            c.j1_cond = C_HIT;
            c.j1_tgt  = S_HIT;
            c.j2_cond = C_MORE;
            c.j2_tgt  = S_SCAN;
         end
         S_MISS: begin
            c.j1_cond = C_FULL;
            c.j1_tgt  = S_OVER;
            c.j2_cond = C_ALWAYS;
            c.j2_tgt  = S_ADD;
         end
         S_ADD: begin
            c.emit    = 1'b1;
            c.add     = 1'b1;
            c.idx_sel = IDX_COUNT;
            c.j1_cond = C_OUT_BUSY;
            c.j1_tgt  = S_ADD;
            c.j2_cond = C_ALWAYS;
            c.j2_tgt  = S_WAIT;
         end
         S_HIT: begin
            c.emit    = 1'b1;
            c.idx_sel = IDX_K;
            c.j1_cond = C_OUT_BUSY;
            c.j1_tgt  = S_HIT;
            c.j2_cond = C_ALWAYS;
            c.j2_tgt  = S_WAIT;
         end
         S_OVER: begin
            c.emit    = 1'b1;
            c.set_ovf = 1'b1;
            c.idx_sel = IDX_ZERO;
            c.j1_cond = C_OUT_BUSY;
            c.j1_tgt  = S_OVER;
            c.j2_cond = C_ALWAYS;
            c.j2_tgt  = S_WAIT;
         end
         default: begin
            c.j1_cond = C_ALWAYS;
            c.j1_tgt  = S_WAIT;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// File: sv/exact_colour_palette_indexer.sv
// Flow: a pixel is taken in the wait step and checked, then the palette RAM scan compares
// one stored colour per cycle from entry 0 until a match, and the hit step emits its index;
// a new colour emits from the add step once all stored entries miss, and an image already
// overflowed skips the scan. A new pixel is taken only after the last result is emitted.
// Reset clears the sequencer, the colour count and the overflow flag; palette contents
// are not cleared, since only entries below the count are ever compared.
`default_nettype none
`include "assert_macros.svh"

module exact_colour_palette_indexer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ecpi_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ecpi_pkg::rsp_type      rsp_data
);

   import ecpi_pkg::*;

   step_type             pc_ff, pc_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   req_type              pix_ff, pix_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   ctrl_type             cw;
   flags_type            flags;
   logic                 j1_taken;
   logic                 j2_taken;
   logic                 accept;
   logic                 fire;
   logic [COLOUR_W-1:0]  rd_colour;
   logic [IDX_W-1:0]     sel_index;

   assign cw = ucode(pc_ff);

   ecpi_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (fire && cw.add),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({pix_ff.red, pix_ff.green, pix_ff.blue}),
      .rd_addr (k_in),
      .rd_data (rd_colour)
   );

   always_comb begin
      flags.no_req   = !req_valid;
      flags.ovf      = ovf_ff;
      flags.empty    = (count_ff == '0);
      flags.hit      = (rd_colour == {pix_ff.red, pix_ff.green, pix_ff.blue});
      flags.more     = ((CNT_W'(k_ff) + CNT_W'(1)) != count_ff);
      flags.full     = (count_ff == CNT_W'(PALETTE_ENTRIES));
      flags.out_busy = rsp_valid_ff && rsp_stall;
      j1_taken       = cond_true(cw.j1_cond, flags);
      j2_taken       = cond_true(cw.j2_cond, flags);
   end

   always_comb begin
      priority if (j1_taken) begin
         pc_in = cw.j1_tgt;
      end else if (j2_taken) begin
         pc_in = cw.j2_tgt;
      end else begin
         pc_in = step_type'(pc_ff + 3'd1);
      end
   end

   always_comb begin
      accept    = cw.take && req_valid;
      fire      = cw.emit && !flags.out_busy;
      req_stall = !cw.take;

      unique case (cw.idx_sel)
         IDX_ZERO:  sel_index = '0;
         IDX_K:     sel_index = k_ff;
         IDX_COUNT: sel_index = count_ff[IDX_W-1:0];
         default:   sel_index = '0;
      endcase

      pix_in = accept ? req_data : pix_ff;

      priority if (accept) begin
         k_in = '0;
      end else if (cw.k_step && !j1_taken) begin
         k_in = k_ff + IDX_W'(1);
      end else begin
         k_in = k_ff;
      end

      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (fire) begin
         if (cw.add) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (cw.set_ovf) begin
            ovf_in = 1'b1;
         end
         if (pix_ff.last_pixel) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end

      rsp_valid_in = fire || flags.out_busy;
      rsp_in       = rsp_ff;
      if (fire) begin
         rsp_in.colour_index = 8'(sel_index);
         rsp_in.new_colour   = cw.add;
         rsp_in.overflow     = ovf_ff || cw.set_ovf;
         rsp_in.entries_used = 9'(count_ff + CNT_W'(cw.add));
         rsp_in.image_done   = pix_ff.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_WAIT;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      pix_ff <= pix_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ECPI_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(PALETTE_ENTRIES), "colour count beyond palette size")
   `ECPI_ASSERT_IMPLY(a_no_add_when_ovf, fire && cw.add, !ovf_ff && !flags.full, "palette append while overflowed or full")
   `ECPI_ASSERT_NEXT(a_accept_goes_check, req_valid && !req_stall, pc_ff == S_CHECK, "accepted transaction did not start a search")
   `ECPI_ASSERT_IMPLY(a_scan_in_range, pc_ff == S_SCAN, CNT_W'(k_ff) < count_ff, "scan index beyond stored entries")

endmodule

`default_nettype wire

// File: sv/ecpi_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; sized by its width and depth parameters.
`default_nettype none

module ecpi_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: sim/exact_colour_palette_indexer_test.sv
// Self-checking testbench for exact_colour_palette_indexer: drives pixel transactions,
// predicts each palette result and compares it with the block's output.
// Depends on ecpi_pkg and the RTL of the block; it reads no files.
`timescale 1ns / 1ps

module exact_colour_palette_indexer_test;
   import ecpi_pkg::*;

   localparam int TOTAL_PIXELS   = 1950;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 300;

   typedef struct {
      logic [23:0] colour;
      bit          last;
      int          fill;
      bit          typed;
      rsp_type     want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [23:0] shadow_palette [PALETTE_ENTRIES];
   int          shadow_count = 0;
   bit          shadow_overflow = 1'b0;

   rsp_type     pending_results [$];
   dir_row_type dir_table [$];
   logic [23:0] colour_pool [$];
   rsp_type     want;
   bit          quiet = 1'b0;
   int          pixels_sent = 0;
   int          results_seen = 0;
   int          bad_results = 0;
   int          idle_cycles = 0;

   exact_colour_palette_indexer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic rsp_type index_pixel(input req_type px);
      rsp_type     r;
      logic [23:0] c;
      bit          hit;
      c = {px.red, px.green, px.blue};
      r = '0;
      r.image_done = px.last_pixel;
      if (!shadow_overflow) begin
         hit = 1'b0;
         for (int k = 0; k < shadow_count && !hit; k++) begin
            if (shadow_palette[k] == c) begin
               r.colour_index = 8'(k);
               hit = 1'b1;
            end
         end
         if (!hit) begin
            if (shadow_count < PALETTE_ENTRIES) begin
               shadow_palette[shadow_count] = c;
               r.colour_index = 8'(shadow_count);
               r.new_colour = 1'b1;
               shadow_count++;
            end else begin
               shadow_overflow = 1'b1;
            end
         end
      end
      r.overflow = shadow_overflow;
      r.entries_used = 9'(shadow_count);
      if (px.last_pixel) begin
         shadow_count = 0;
         shadow_overflow = 1'b0;
      end
      return r;
   endfunction

   function automatic req_type pixel(input logic [23:0] c, input bit last);
      req_type px;
      px.red = c[23:16];
      px.green = c[15:8];
      px.blue = c[7:0];
      px.last_pixel = last;
      return px;
   endfunction

   function automatic dir_row_type row(input logic [23:0] colour, input bit last,
                                       input int fill, input bit typed,
                                       input logic [7:0] idx, input bit nw,
                                       input bit ovf, input logic [8:0] cnt);
      dir_row_type d;
      d.colour = colour;
      d.last = last;
      d.fill = fill;
      d.typed = typed;
      d.want.colour_index = idx;
      d.want.new_colour = nw;
      d.want.overflow = ovf;
      d.want.entries_used = cnt;
      d.want.image_done = last;
      return d;
   endfunction

   task automatic drive_pixel(input req_type px, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      quiet = pixels_sent >= 600 && pixels_sent < 1000;
      if (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = index_pixel(px);
      pending_results.push_back(typed ? typed_rsp : predicted);
      pixels_sent++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("Result transaction %0d arrived with nothing expected: %p",
                           results_seen, rsp_data);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.colour_index !== want.colour_index ||
                   rsp_data.new_colour !== want.new_colour ||
                   rsp_data.overflow !== want.overflow ||
                   rsp_data.entries_used !== want.entries_used ||
                   rsp_data.image_done !== want.image_done) begin
                  bad_results++;
                  if (bad_results <= 10)
                     $display("Result transaction %0d mismatch: expected %p, got %p",
                              results_seen, want, rsp_data);
               end
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 6);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      int          len;
      int          pool_size;
      int          distinct;
      logic [23:0] c;

      dir_table.push_back(row(24'h000000, 1'b0, 0, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1));
      dir_table.push_back(row(24'h000000, 1'b0, 0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd1));
      dir_table.push_back(row(24'hFFFFFF, 1'b0, 0, 1'b1, 8'd1, 1'b1, 1'b0, 9'd2));
      dir_table.push_back(row(24'hFF0000, 1'b0, 0, 1'b1, 8'd2, 1'b1, 1'b0, 9'd3));
      dir_table.push_back(row(24'h00FF00, 1'b0, 0, 1'b1, 8'd3, 1'b1, 1'b0, 9'd4));
      dir_table.push_back(row(24'h0000FF, 1'b0, 0, 1'b1, 8'd4, 1'b1, 1'b0, 9'd5));
      dir_table.push_back(row(24'hFFFFFF, 1'b0, 0, 1'b1, 8'd1, 1'b0, 1'b0, 9'd5));
      dir_table.push_back(row(24'h00FF00, 1'b1, 0, 1'b1, 8'd3, 1'b0, 1'b0, 9'd5));
      dir_table.push_back(row(24'hFFFFFF, 1'b0, 0, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1));
      dir_table.push_back(row(24'h100000, 1'b0, 255, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0));
      dir_table.push_back(row(24'h0A0B0C, 1'b0, 0, 1'b1, 8'd0, 1'b0, 1'b1, 9'd256));
      dir_table.push_back(row(24'hFFFFFF, 1'b0, 0, 1'b1, 8'd0, 1'b0, 1'b1, 9'd256));
      dir_table.push_back(row(24'h100005, 1'b1, 0, 1'b1, 8'd0, 1'b0, 1'b1, 9'd256));
      dir_table.push_back(row(24'h123456, 1'b0, 0, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1));
      dir_table.push_back(row(24'h200000, 1'b0, 254, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0));
      dir_table.push_back(row(24'h123456, 1'b0, 0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd255));
      dir_table.push_back(row(24'h2000FD, 1'b0, 0, 1'b1, 8'd254, 1'b0, 1'b0, 9'd255));
      dir_table.push_back(row(24'hABCDEF, 1'b0, 0, 1'b1, 8'd255, 1'b1, 1'b0, 9'd256));
      dir_table.push_back(row(24'hABCDEF, 1'b0, 0, 1'b1, 8'd255, 1'b0, 1'b0, 9'd256));
      dir_table.push_back(row(24'h000000, 1'b1, 0, 1'b1, 8'd0, 1'b0, 1'b1, 9'd256));
      dir_table.push_back(row(24'h000000, 1'b1, 0, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[r]) begin
         if (dir_table[r].fill == 0) begin
            drive_pixel(pixel(dir_table[r].colour, dir_table[r].last), dir_table[r].typed,
                        dir_table[r].want);
         end else begin
            for (int n = 0; n < dir_table[r].fill; n++)
               drive_pixel(pixel(dir_table[r].colour + 24'(n), 1'b0), 1'b0, '0);
         end
      end

      while (pixels_sent < TOTAL_PIXELS) begin
         case ($urandom_range(99)) inside
            [0:4]: begin
               // A long image that fills the palette and usually runs past it.
               colour_pool.delete();
               distinct = $urandom_range(270, 250);
               for (int i = 0; i < distinct; i++) begin
                  c = 24'($urandom);
                  colour_pool.push_back(c);
                  drive_pixel(pixel(c, 1'b0), 1'b0, '0);
               end
               repeat (20) begin
                  c = $urandom_range(1) ? colour_pool[$urandom_range(colour_pool.size() - 1)]
                                        : 24'($urandom);
                  drive_pixel(pixel(c, 1'b0), 1'b0, '0);
               end
               drive_pixel(pixel(colour_pool[$urandom_range(colour_pool.size() - 1)], 1'b1),
                           1'b0, '0);
            end
            [5:14]: begin
               repeat ($urandom_range(3, 1))
                  drive_pixel(pixel(24'($urandom), 1'($urandom_range(1))), 1'b0, '0);
            end
            default: begin
               colour_pool.delete();
               pool_size = $urandom_range(16, 1);
               repeat (pool_size) colour_pool.push_back(24'($urandom));
               len = $urandom_range(40, 1);
               for (int i = 0; i < len; i++) begin
                  c = ($urandom_range(9) == 0) ? 24'($urandom)
                                               : colour_pool[$urandom_range(pool_size - 1)];
                  drive_pixel(pixel(c, i == len - 1), 1'b0, '0);
               end
            end
         endcase
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_results == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/ecpi_pkg.sv
sv/ecpi_ram.sv
sv/exact_colour_palette_indexer.sv
sim/exact_colour_palette_indexer_test.sv
